// ----- hw/rtl/wss_pkg.sv -----
// package for windowed sample statistics
// holds depth constants, action codes and payload types, no dependencies
`timescale 1ns / 1ps
package wss_pkg;
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_COMPUTE = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] sample_value;
    logic [31:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  sample_count;
    logic [31:0] mean_value;
    logic [15:0] std_dev;
    logic [31:0] max_value;
    logic [31:0] max_stamp;
  } out_item_t;
endpackage

// ----- hw/rtl/wss_in_if.sv -----
// valid/ready channel carrying one input item
// depends on wss_pkg
`timescale 1ns / 1ps
interface wss_in_if import wss_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/wss_out_if.sv -----
// valid/ready channel carrying one result item
// depends on wss_pkg
`timescale 1ns / 1ps
interface wss_out_if import wss_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/windowed_sample_statistics_core.sv -----
// windowed sample statistics top level, depends on wss_pkg, wss_in_if, wss_out_if
// add, clear and unused action: from S_IDLE through S_OUT to the result;
// compute: S_SCAN and S_DIV1, ending there if no sample or only one is kept, else on
// via S_DEV, S_DIV2, S_SQRT (2 store walks, 2 bit-serial 32-bit divides, 16-step root)
// throughput: one item at a time, input ready again once the result is taken
// reset: async active low clears the stores, peak, results and max_age
`timescale 1ns / 1ps
module windowed_sample_statistics_core import wss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  wss_in_if.sink      in_if,
  wss_out_if.source   out_if
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DIV1, S_DEV, S_DIV2, S_SQRT, S_OUT
  } state_e;

  state_e            state_q;
  logic [31:0]       max_age_q;
  logic [31:0]       val_q [Depth];
  logic [31:0]       tim_q [Depth];
  logic [IdxW-1:0]   wslot_q;
  logic [31:0]       peak_v_q, peak_t_q, mean_q;
  logic [15:0]       dev_q;
  logic [CntW-1:0]   cnt_q;
  logic [Depth-1:0]  pick_q;
  logic [CntW-1:0]   idx_q;
  logic              stop_q;
  logic [31:0]       now_q, sum_q;
  logic [31:0]       quo_q;
  logic [32:0]       rem_q;
  logic [5:0]        step_q;
  logic [15:0]       root_q;
  logic              busy_q, ovalid_q;

  logic [IdxW-1:0]   idx;
  logic [31:0]       cur_v, cur_t, tdiff, dlt;
  logic [31:0]       sq;
  logic              keep;
  logic [32:0]       rem_sh;
  logic [15:0]       trial;
  logic [31:0]       tsq;

  assign idx   = idx_q[IdxW-1:0];
  assign cur_v = val_q[idx];
  assign cur_t = tim_q[idx];
  assign tdiff = (now_q >= cur_t) ? now_q - cur_t : cur_t - now_q;
  assign keep  = (max_age_q == '0) || (now_q == '0) || (tdiff <= max_age_q);
  assign dlt   = cur_v - mean_q;
  assign sq    = dlt * dlt;
  assign rem_sh = {rem_q[31:0], sum_q[31]};
  assign trial = root_q | (16'h8000 >> step_q[3:0]);
  assign tsq   = trial * trial;

  assign in_if.ready  = !busy_q && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = '{sample_count: 5'(cnt_q), mean_value: mean_q,
                          std_dev: dev_q, max_value: peak_v_q, max_stamp: peak_t_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      max_age_q <= '0;
      for (int i = 0; i < Depth; i++) begin
        val_q[i] <= '0;
        tim_q[i] <= '0;
      end
      wslot_q <= '0; peak_v_q <= '0; peak_t_q <= '0; mean_q <= '0;
      dev_q <= '0; cnt_q <= '0; pick_q <= '0; idx_q <= '0; stop_q <= 1'b0;
      now_q <= '0; sum_q <= '0; quo_q <= '0; rem_q <= '0; step_q <= '0;
      root_q <= '0; busy_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_age_q <= cfg_wdata_i;
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            case (action_e'(in_if.data.action))
              ACT_ADD: begin
                if (in_if.data.stamp != '0) begin
                  val_q[wslot_q] <= in_if.data.sample_value;
                  tim_q[wslot_q] <= in_if.data.stamp;
                  wslot_q <= (wslot_q == IdxW'(Depth - 1)) ? '0 : wslot_q + 1'b1;
                  if (in_if.data.sample_value > peak_v_q) begin
                    peak_v_q <= in_if.data.sample_value;
                    peak_t_q <= in_if.data.stamp;
                  end
                end
                state_q <= S_OUT;
              end
              ACT_COMPUTE: begin
                peak_v_q <= '0; peak_t_q <= '0; cnt_q <= '0; sum_q <= '0;
                pick_q <= '0; idx_q <= '0; stop_q <= 1'b0;
                now_q <= in_if.data.stamp; state_q <= S_SCAN;
              end
              ACT_CLEAR: begin
                for (int i = 0; i < Depth; i++) begin
                  val_q[i] <= '0;
                  tim_q[i] <= '0;
                end
                wslot_q <= '0; peak_v_q <= '0; peak_t_q <= '0; mean_q <= '0;
                dev_q <= '0; cnt_q <= '0;
                state_q <= S_OUT;
              end
              default: state_q <= S_OUT;
            endcase
            busy_q <= 1'b1;
          end
        end
        S_SCAN: begin
          if (cur_t == '0) stop_q <= 1'b1;
          if (cur_t != '0 && !stop_q && keep) begin
            pick_q[idx] <= 1'b1;
            sum_q <= sum_q + cur_v;
            cnt_q <= cnt_q + 1'b1;
            if (cur_v > peak_v_q) begin
              peak_v_q <= cur_v;
              peak_t_q <= cur_t;
            end
          end
          if (idx_q == CntW'(Depth - 1)) begin
            rem_q <= '0; quo_q <= '0; step_q <= '0;
            state_q <= S_DIV1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DIV1, S_DIV2: begin
          if (cnt_q == '0) begin
            mean_q <= '0; dev_q <= '0; state_q <= S_OUT;
          end else begin
            sum_q <= {sum_q[30:0], 1'b0};
            if (rem_sh >= 33'(cnt_q)) begin
              rem_q <= rem_sh - 33'(cnt_q);
              quo_q <= {quo_q[30:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[30:0], 1'b0};
            end
            if (step_q == 6'd31) begin
              step_q <= '0;
              if (state_q == S_DIV1) begin
                mean_q <= {quo_q[30:0], (rem_sh >= 33'(cnt_q))};
                if (cnt_q == CntW'(1)) begin
                  dev_q <= '0; state_q <= S_OUT;
                end else begin
                  idx_q <= '0; state_q <= S_DEV;
                end
              end else begin
                root_q <= '0; state_q <= S_SQRT;
              end
            end else begin
              step_q <= step_q + 1'b1;
            end
          end
        end
        S_DEV: begin
          if (idx_q == '0) sum_q <= pick_q[idx] ? sq : '0;
          else if (pick_q[idx]) sum_q <= sum_q + sq;
          if (idx_q == CntW'(Depth - 1)) begin
            rem_q <= '0; quo_q <= '0; step_q <= '0;
            state_q <= S_DIV2;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SQRT: begin
          if (tsq <= quo_q) root_q <= trial;
          step_q <= step_q + 1'b1;
          if (step_q == 6'd15) begin
            dev_q <= (tsq <= quo_q) ? trial : root_q;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          ovalid_q <= 1'b1; busy_q <= 1'b0; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
